// ----- rtl/glq_pkg.sv -----
// Package for the glyph quad layout block: types, codes and shared arithmetic.
`timescale 1ns / 1ps
package glq_pkg;

  localparam int PosW    = 24;
  localparam int TexW    = 17;
  localparam int OffW    = 20;
  localparam int SizeW   = 17;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 24;
  localparam int FifoAw  = 2;

  localparam logic [7:0] CH_NL  = 8'd10;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_NUL = 8'd0;

  localparam logic [CfgIdxW-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SCALE       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FONT_SIZE   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_INV_WIDTH   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_INV_HEIGHT  = 3'd5;

  localparam logic [2:0] VERT_FIRST = 3'd0;
  localparam logic [2:0] VERT_LAST  = 3'd5;

  // corner selects per vertex, bit k for vertex k
  localparam logic [5:0] SELX = 6'b110100;
  localparam logic [5:0] SELY = 6'b010110;

  localparam logic signed [27:0] SAT_HI = 28'sd8388607;
  localparam logic signed [27:0] SAT_LO = -28'sd8388608;

  typedef struct packed {
    logic signed [PosW-1:0] origin_x;
    logic signed [PosW-1:0] origin_y;
    logic [15:0]            scale_factor;
    logic [7:0]             font_size;
    logic [23:0]            inv_atlas_width;
    logic [23:0]            inv_atlas_height;
  } glq_cfg_t;

  typedef struct packed {
    logic signed [PosW-1:0] pen_x;
    logic signed [PosW-1:0] pen_y;
    logic signed [OffW-1:0] off_x;
    logic signed [OffW-1:0] off_y;
    logic [SizeW-1:0]       size_w;
    logic [SizeW-1:0]       size_h;
    logic [11:0]            atlas_x;
    logic [11:0]            atlas_y;
    logic [7:0]             glyph_width;
    logic [7:0]             glyph_height;
    logic                   final_char;
  } glq_char_t;

  // pixels times Q4.12 scale, rounded half up to Q.4
  function automatic logic signed [OffW-1:0] scaled(input logic signed [10:0] pix,
                                                    input logic [15:0] s);
    logic signed [27:0] t;
    t = $signed({{17{pix[10]}}, pix}) * $signed({12'd0, s});
    t = t + 28'sd128;
    return t[27:8];
  endfunction

  function automatic logic signed [PosW-1:0] sat24(input logic signed [27:0] v);
    logic signed [PosW-1:0] r;
    if (v > SAT_HI) begin
      r = 24'sh7FFFFF;
    end else if (v < SAT_LO) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  function automatic logic [TexW-1:0] texc(input logic [12:0] coord, input logic [23:0] inv);
    logic [36:0] p;
    logic [TexW-1:0] r;
    p = {24'd0, coord} * {13'd0, inv};
    p = p + 37'd128;
    if (p[36:8] > 29'd65536) begin
      r = 17'd65536;
    end else begin
      r = p[24:8];
    end
    return r;
  endfunction

endpackage

// ----- rtl/glq_fifo.sv -----
// Four-entry queue of classified characters between front and back.
`timescale 1ns / 1ps
module glq_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  glq_pkg::glq_char_t  push_data,
  input  logic                pop,
  output glq_pkg::glq_char_t  pop_data,
  output logic                full,
  output logic                empty
);

  localparam int Depth = 1 << glq_pkg::FifoAw;

  glq_pkg::glq_char_t mem [Depth];
  logic [glq_pkg::FifoAw-1:0] wr_ptr_r, rd_ptr_r;
  logic [glq_pkg::FifoAw:0]   count_r;

  assign full     = (count_r == (glq_pkg::FifoAw+1)'(Depth));
  assign empty    = (count_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/glq_front.sv -----
// Front end: takes characters, keeps the pen state and queues printable glyphs.
`timescale 1ns / 1ps
module glq_front (
  input  logic                clk,
  input  logic                rst_n,
  input  glq_pkg::glq_cfg_t   cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_char_code,
  input  logic [7:0]          in_glyph_width,
  input  logic [7:0]          in_glyph_height,
  input  logic signed [7:0]   in_bearing_left,
  input  logic signed [7:0]   in_bearing_top,
  input  logic [11:0]         in_atlas_x,
  input  logic [11:0]         in_atlas_y,
  input  logic [15:0]         in_advance_units,
  input  logic                in_first_char,
  input  logic                in_final_char,
  output logic                push,
  output glq_pkg::glq_char_t  push_data,
  input  logic                fifo_full
);

  logic signed [glq_pkg::PosW-1:0]  pen_x_r, pen_x_nxt, pen_y_r, pen_y_nxt;
  logic [glq_pkg::SizeW-1:0]        lmh_r, lmh_nxt;
  logic [7:0]                       pla_r, pla_nxt;

  logic signed [glq_pkg::PosW-1:0]  pen_x_b, pen_y_b;
  logic [glq_pkg::SizeW-1:0]        lmh_b;
  logic [7:0]                       pla_b;
  logic signed [27:0]               fs16, pla16;
  logic                             is_nl, is_tab, is_nul, take;
  logic signed [10:0]               adv_pix, off_y_pix;
  logic signed [glq_pkg::OffW-1:0]  adv_s, off_x, off_y, size_w, size_h;
  logic signed [glq_pkg::PosW-1:0]  pen_x_adv;

  assign in_stall = fifo_full;
  assign take     = in_valid && !in_stall;

  always_comb begin
    is_nl  = (in_char_code == glq_pkg::CH_NL);
    is_tab = (in_char_code == glq_pkg::CH_TAB);
    is_nul = (in_char_code == glq_pkg::CH_NUL);

    fs16  = $signed({16'd0, cfg.font_size, 4'd0});

    pen_x_b = in_first_char ? cfg.origin_x : pen_x_r;
    pen_y_b = in_first_char
              ? glq_pkg::sat24($signed({{4{cfg.origin_y[23]}}, cfg.origin_y}) + fs16)
              : pen_y_r;
    lmh_b   = in_first_char ? '0 : lmh_r;
    pla_b   = in_first_char ? '0 : pla_r;

    pla16 = $signed({16'd0, pla_b, 4'd0});

    adv_pix   = is_tab ? $signed({2'b00, in_glyph_width, 1'b0})
                       : $signed({1'b0, in_advance_units[15:6]});
    off_y_pix = $signed({3'b000, in_glyph_height}) -
                $signed({{3{in_bearing_top[7]}}, in_bearing_top});

    adv_s  = glq_pkg::scaled(adv_pix, cfg.scale_factor);
    off_x  = glq_pkg::scaled($signed({{3{in_bearing_left[7]}}, in_bearing_left}),
                             cfg.scale_factor);
    off_y  = glq_pkg::scaled(off_y_pix, cfg.scale_factor);
    size_w = glq_pkg::scaled($signed({3'b000, in_glyph_width}), cfg.scale_factor);
    size_h = glq_pkg::scaled($signed({3'b000, in_glyph_height}), cfg.scale_factor);

    pen_x_adv = glq_pkg::sat24($signed({{4{pen_x_b[23]}}, pen_x_b}) +
                               $signed({{8{adv_s[19]}}, adv_s}));

    pen_x_nxt = pen_x_b;
    pen_y_nxt = pen_y_b;
    lmh_nxt   = lmh_b;
    pla_nxt   = pla_b;
    priority if (is_nl) begin
      pen_x_nxt = cfg.origin_x;
      lmh_nxt   = '0;
      if (lmh_b != '0) begin
        pen_y_nxt = glq_pkg::sat24($signed({{4{pen_y_b[23]}}, pen_y_b}) + fs16);
        pla_nxt   = cfg.font_size;
      end else begin
        pen_y_nxt = glq_pkg::sat24($signed({{4{pen_y_b[23]}}, pen_y_b}) + pla16);
      end
    end else if (is_tab) begin
      pen_x_nxt = pen_x_adv;
    end else if (is_nul) begin
      pen_x_nxt = pen_x_b;
    end else begin
      pen_x_nxt = pen_x_adv;
      if (size_h[glq_pkg::SizeW-1:0] > lmh_b) lmh_nxt = size_h[glq_pkg::SizeW-1:0];
    end

    push = take && !is_nl && !is_tab && !is_nul;

    push_data.pen_x        = pen_x_b;
    push_data.pen_y        = pen_y_b;
    push_data.off_x        = off_x;
    push_data.off_y        = off_y;
    push_data.size_w       = size_w[glq_pkg::SizeW-1:0];
    push_data.size_h       = size_h[glq_pkg::SizeW-1:0];
    push_data.atlas_x      = in_atlas_x;
    push_data.atlas_y      = in_atlas_y;
    push_data.glyph_width  = in_glyph_width;
    push_data.glyph_height = in_glyph_height;
    push_data.final_char   = in_final_char;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
      lmh_r   <= '0;
      pla_r   <= '0;
    end else if (take) begin
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
      lmh_r   <= lmh_nxt;
      pla_r   <= pla_nxt;
    end
  end

endmodule

// ----- rtl/glq_back.sv -----
// Back end: builds the quad corners of a queued glyph and streams six vertices.
`timescale 1ns / 1ps
module glq_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  glq_pkg::glq_cfg_t                cfg,
  input  glq_pkg::glq_char_t               head,
  input  logic                             fifo_empty,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [glq_pkg::PosW-1:0]  out_vert_x,
  output logic signed [glq_pkg::PosW-1:0]  out_vert_y,
  output logic [glq_pkg::TexW-1:0]         out_tex_u,
  output logic [glq_pkg::TexW-1:0]         out_tex_v,
  output logic [2:0]                       out_vertex_number,
  output logic                             out_last_vertex,
  output logic                             out_end_of_string
);

  logic                            quad_valid_r;
  logic [2:0]                      k_r;
  logic signed [glq_pkg::PosW-1:0] qx0_r, qx1_r, qy0_r, qy1_r;
  logic [glq_pkg::TexW-1:0]        qu0_r, qu1_r, qv0_r, qv1_r;
  logic                            qfinal_r;

  logic                            out_valid_r;
  logic signed [glq_pkg::PosW-1:0] vx_r, vy_r;
  logic [glq_pkg::TexW-1:0]        tu_r, tv_r;
  logic [2:0]                      vn_r;
  logic                            lv_r, eos_r;

  logic                            emit, quad_done, load, sx, sy;
  logic signed [27:0]              xa, xb, ya, yt;

  assign emit      = quad_valid_r && (!out_valid_r || !out_stall);
  assign quad_done = emit && (k_r == glq_pkg::VERT_LAST);
  assign load      = !fifo_empty && (!quad_valid_r || quad_done);
  assign pop       = load;
  assign sx        = glq_pkg::SELX[k_r];
  assign sy        = glq_pkg::SELY[k_r];

  always_comb begin
    xa = $signed({{4{head.pen_x[23]}}, head.pen_x}) +
         $signed({{8{head.off_x[19]}}, head.off_x});
    xb = xa + $signed({11'd0, head.size_w});
    ya = $signed({{4{head.pen_y[23]}}, head.pen_y}) +
         $signed({{8{head.off_y[19]}}, head.off_y});
    yt = ya - $signed({11'd0, head.size_h});
  end

  always_ff @(posedge clk) begin
    if (load) begin
      qx0_r    <= glq_pkg::sat24(xa);
      qx1_r    <= glq_pkg::sat24(xb);
      qy0_r    <= glq_pkg::sat24(yt);
      qy1_r    <= glq_pkg::sat24(ya);
      qu0_r    <= glq_pkg::texc({1'b0, head.atlas_x}, cfg.inv_atlas_width);
      qu1_r    <= glq_pkg::texc({1'b0, head.atlas_x} + {5'd0, head.glyph_width},
                                cfg.inv_atlas_width);
      qv0_r    <= glq_pkg::texc({1'b0, head.atlas_y}, cfg.inv_atlas_height);
      qv1_r    <= glq_pkg::texc({1'b0, head.atlas_y} + {5'd0, head.glyph_height},
                                cfg.inv_atlas_height);
      qfinal_r <= head.final_char;
    end
    if (emit) begin
      vx_r  <= sx ? qx1_r : qx0_r;
      vy_r  <= sy ? qy1_r : qy0_r;
      tu_r  <= sx ? qu1_r : qu0_r;
      tv_r  <= sy ? qv1_r : qv0_r;
      vn_r  <= k_r;
      lv_r  <= (k_r == glq_pkg::VERT_LAST);
      eos_r <= (k_r == glq_pkg::VERT_LAST) && qfinal_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_valid_r <= 1'b0;
      k_r          <= glq_pkg::VERT_FIRST;
      out_valid_r  <= 1'b0;
    end else begin
      if (load) begin
        quad_valid_r <= 1'b1;
      end else if (quad_done) begin
        quad_valid_r <= 1'b0;
      end
      if (load || quad_done) begin
        k_r <= glq_pkg::VERT_FIRST;
      end else if (emit) begin
        k_r <= k_r + 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_vert_x        = vx_r;
  assign out_vert_y        = vy_r;
  assign out_tex_u         = tu_r;
  assign out_tex_v         = tv_r;
  assign out_vertex_number = vn_r;
  assign out_last_vertex   = lv_r;
  assign out_end_of_string = eos_r;

endmodule

// ----- rtl/glyph_quad_layout_top.sv -----
// Top level of the glyph quad layout block: configuration registers and wiring.
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_stall   one character with glyph metrics
//   out_      output     out_valid / out_stall one vertex of a glyph quad
//   cfg_      input      cfg_we                cfg_index, cfg_data
//
// A character is taken every cycle while the four-entry queue has room; pen state
// updates in that same cycle. The back end emits one vertex per cycle while out_stall
// is low, from a registered quad, so a printable character yields six vertices;
// newline, tab and NUL produce no output. Reset (rst_n low, synchronous) empties
// the queue and output register and restores register defaults.
// in_stall rises only when the queue is full.
`timescale 1ns / 1ps
module glyph_quad_layout_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [glq_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [glq_pkg::CfgW-1:0]         cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_char_code,
  input  logic [7:0]                       in_glyph_width,
  input  logic [7:0]                       in_glyph_height,
  input  logic signed [7:0]                in_bearing_left,
  input  logic signed [7:0]                in_bearing_top,
  input  logic [11:0]                      in_atlas_x,
  input  logic [11:0]                      in_atlas_y,
  input  logic [15:0]                      in_advance_units,
  input  logic                             in_first_char,
  input  logic                             in_final_char,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [glq_pkg::PosW-1:0]  out_vert_x,
  output logic signed [glq_pkg::PosW-1:0]  out_vert_y,
  output logic [glq_pkg::TexW-1:0]         out_tex_u,
  output logic [glq_pkg::TexW-1:0]         out_tex_v,
  output logic [2:0]                       out_vertex_number,
  output logic                             out_last_vertex,
  output logic                             out_end_of_string
);

  glq_pkg::glq_cfg_t  cfg_r;
  glq_pkg::glq_char_t push_data, head;
  logic               push, pop, fifo_full, fifo_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x         <= '0;
      cfg_r.origin_y         <= '0;
      cfg_r.scale_factor     <= 16'd4096;
      cfg_r.font_size        <= 8'd16;
      cfg_r.inv_atlas_width  <= 24'd65536;
      cfg_r.inv_atlas_height <= 24'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        glq_pkg::REG_ORIGIN_X:   cfg_r.origin_x         <= cfg_data;
        glq_pkg::REG_ORIGIN_Y:   cfg_r.origin_y         <= cfg_data;
        glq_pkg::REG_SCALE:      cfg_r.scale_factor     <= cfg_data[15:0];
        glq_pkg::REG_FONT_SIZE:  cfg_r.font_size        <= cfg_data[7:0];
        glq_pkg::REG_INV_WIDTH:  cfg_r.inv_atlas_width  <= cfg_data;
        glq_pkg::REG_INV_HEIGHT: cfg_r.inv_atlas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  glq_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_glyph_width   (in_glyph_width),
    .in_glyph_height  (in_glyph_height),
    .in_bearing_left  (in_bearing_left),
    .in_bearing_top   (in_bearing_top),
    .in_atlas_x       (in_atlas_x),
    .in_atlas_y       (in_atlas_y),
    .in_advance_units (in_advance_units),
    .in_first_char    (in_first_char),
    .in_final_char    (in_final_char),
    .push             (push),
    .push_data        (push_data),
    .fifo_full        (fifo_full)
  );

  glq_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (head),
    .full      (fifo_full),
    .empty     (fifo_empty)
  );

  glq_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .head              (head),
    .fifo_empty        (fifo_empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_vert_x        (out_vert_x),
    .out_vert_y        (out_vert_y),
    .out_tex_u         (out_tex_u),
    .out_tex_v         (out_tex_v),
    .out_vertex_number (out_vertex_number),
    .out_last_vertex   (out_last_vertex),
    .out_end_of_string (out_end_of_string)
  );

endmodule
